// ----- hw/rtl/rms_feedforward_compressor_top_macros.svh -----
// Assertion macros shared by the compressor RTL.
// All of them sample on clk_i and stay off while rst_ni is low.
`ifndef RMS_FEEDFORWARD_COMPRESSOR_TOP_MACROS_SVH
`define RMS_FEEDFORWARD_COMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication.
`define RFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rfc_pkg.sv -----
package rfc_pkg;

  localparam int MAX_CHANNELS = 2;

  localparam logic [23:0] ONE_Q23     = 24'h80_0000;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [47:0] FLUSH_LIMIT = 48'd1407374;
  localparam logic [22:0] LOG_OFFSET  = 23'h3F_0000;
  localparam logic [3:0]  NRM_LAST    = 4'd5;
  localparam logic [3:0]  STEP_LAST   = 4'd15;

  // Configuration register indexes.
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_INV = 3'd1;
  localparam logic [2:0] REG_GAIN_EXPONENT = 3'd2;
  localparam logic [2:0] REG_ATTACK_COEF   = 3'd3;
  localparam logic [2:0] REG_RELEASE_COEF  = 3'd4;
  localparam logic [2:0] REG_RMS_COEF      = 3'd5;
  localparam logic [2:0] REG_DRY_GAIN      = 3'd6;
  localparam logic [2:0] REG_WET_MAKEUP    = 3'd7;

  // Sequencer step codes, also the operation the datapath executes.
  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_SQ    = 5'd1;
  localparam logic [4:0] OP_MS0   = 5'd2;
  localparam logic [4:0] OP_MS1   = 5'd3;
  localparam logic [4:0] OP_MS2   = 5'd4;
  localparam logic [4:0] OP_MS3   = 5'd5;
  localparam logic [4:0] OP_MS4   = 5'd6;
  localparam logic [4:0] OP_EN0   = 5'd7;
  localparam logic [4:0] OP_EN1   = 5'd8;
  localparam logic [4:0] OP_EN2   = 5'd9;
  localparam logic [4:0] OP_EN3   = 5'd10;
  localparam logic [4:0] OP_EN4   = 5'd11;
  localparam logic [4:0] OP_TH0   = 5'd12;
  localparam logic [4:0] OP_TH1   = 5'd13;
  localparam logic [4:0] OP_TH2   = 5'd14;
  localparam logic [4:0] OP_DEC   = 5'd15;
  localparam logic [4:0] OP_NINIT = 5'd16;
  localparam logic [4:0] OP_NRM   = 5'd17;
  localparam logic [4:0] OP_LG0   = 5'd18;
  localparam logic [4:0] OP_LGS   = 5'd19;
  localparam logic [4:0] OP_LGE   = 5'd20;
  localparam logic [4:0] OP_LSUM  = 5'd21;
  localparam logic [4:0] OP_MULM  = 5'd22;
  localparam logic [4:0] OP_MEND  = 5'd23;
  localparam logic [4:0] OP_POW   = 5'd24;
  localparam logic [4:0] OP_PEND  = 5'd25;
  localparam logic [4:0] OP_BYP   = 5'd26;
  localparam logic [4:0] OP_FAC0  = 5'd27;
  localparam logic [4:0] OP_FAC1  = 5'd28;
  localparam logic [4:0] OP_SC0   = 5'd29;
  localparam logic [4:0] OP_SC1   = 5'd30;
  localparam logic [4:0] OP_SC2   = 5'd31;

  typedef logic signed [23:0] sample_t;

  typedef struct packed {
    logic [1:0]         channel_count;
    logic [35:0]        threshold_inverse;
    logic signed [15:0] gain_exponent;
    logic [23:0]        attack_coef;
    logic [23:0]        release_coef;
    logic [23:0]        rms_coef;
    logic [16:0]        dry_gain;
    logic [22:0]        wet_makeup_gain;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] cnt;
    logic       sel_ti;
    logic       take;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    n = n_in;
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > n) begin
        bit_v = bit_v >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != '0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Successive square roots of two in Q2.30, evaluated at elaboration.
  function automatic logic [15:0][31:0] build_roots();
    logic [63:0]       r;
    logic [15:0][31:0] t;
    r = isqrt64(64'h2000_0000_0000_0000);
    t[0] = r[31:0];
    for (int j = 1; j < 16; j++) begin
      r = isqrt64({r[33:0], 30'b0});
      t[j] = r[31:0];
    end
    return t;
  endfunction

  localparam logic [15:0][31:0] ROOT_TABLE = build_roots();

endpackage

// ----- hw/rtl/rfc_if.sv -----
interface rfc_in_if;
  logic             valid;
  logic             ready;
  rfc_pkg::sample_t sample_a;
  rfc_pkg::sample_t sample_b;

  modport source(output valid, output sample_a, output sample_b, input ready);
  modport sink(input valid, input sample_a, input sample_b, output ready);
endinterface

interface rfc_out_if;
  logic             valid;
  logic             ready;
  rfc_pkg::sample_t out_a;
  rfc_pkg::sample_t out_b;

  modport source(output valid, output out_a, output out_b, input ready);
  modport sink(input valid, input out_a, input out_b, output ready);
endinterface

// ----- hw/rtl/rfc_ctrl.sv -----
`include "rms_feedforward_compressor_top_macros.svh"

module rfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rfc_pkg::stat_t stat_i,
  output rfc_pkg::cmd_t  cmd_o
);
  import rfc_pkg::*;

  logic [4:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       which_q, which_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    which_d = which_q;
    case (state_q)
      OP_IDLE:  if (in_valid_i) state_d = OP_SQ;
      OP_SQ:    state_d = OP_MS0;
      OP_MS0:   state_d = OP_MS1;
      OP_MS1:   state_d = OP_MS2;
      OP_MS2:   state_d = OP_MS3;
      OP_MS3:   state_d = OP_MS4;
      OP_MS4:   state_d = OP_EN0;
      OP_EN0:   state_d = OP_EN1;
      OP_EN1:   state_d = OP_EN2;
      OP_EN2:   state_d = OP_EN3;
      OP_EN3:   state_d = OP_EN4;
      OP_EN4:   state_d = OP_TH0;
      OP_TH0:   state_d = OP_TH1;
      OP_TH1:   state_d = OP_TH2;
      OP_TH2:   state_d = OP_DEC;
      OP_DEC: begin
        which_d = 1'b0;
        state_d = stat_i.bypass ? OP_BYP : OP_NINIT;
      end
      OP_NINIT: begin
        cnt_d   = '0;
        state_d = OP_NRM;
      end
      OP_NRM: begin
        if (cnt_q == NRM_LAST) begin
          cnt_d   = '0;
          state_d = OP_LG0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      OP_LG0: begin
        cnt_d   = '0;
        state_d = OP_LGS;
      end
      OP_LGS: begin
        if (cnt_q == STEP_LAST) begin
          state_d = OP_LGE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      OP_LGE: begin
        if (which_q) begin
          state_d = OP_LSUM;
        end else begin
          which_d = 1'b1;
          state_d = OP_NINIT;
        end
      end
      OP_LSUM:  state_d = OP_MULM;
      OP_MULM:  state_d = OP_MEND;
      OP_MEND: begin
        cnt_d   = '0;
        state_d = OP_POW;
      end
      OP_POW: begin
        if (cnt_q == STEP_LAST) begin
          state_d = OP_PEND;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      OP_PEND:  state_d = OP_FAC0;
      OP_BYP:   state_d = OP_FAC0;
      OP_FAC0:  state_d = OP_FAC1;
      OP_FAC1:  state_d = OP_SC0;
      OP_SC0:   state_d = OP_SC1;
      OP_SC1:   state_d = OP_SC2;
      OP_SC2:   if (stat_i.out_free) state_d = OP_IDLE;
      default:  state_d = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_IDLE;
      cnt_q   <= '0;
      which_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      which_q <= which_d;
    end
  end

  assign in_ready_o   = (state_q == OP_IDLE);
  assign cmd_o.op     = state_q;
  assign cmd_o.cnt    = cnt_q;
  assign cmd_o.sel_ti = which_q;
  assign cmd_o.take   = (state_q == OP_IDLE) && in_valid_i;

  `RFC_ASSERT_NEXT(a_take_starts, cmd_o.take, state_q == OP_SQ, "accepted frame did not start")
  `RFC_ASSERT_IMP(a_nrm_count, state_q == OP_NRM, cnt_q <= NRM_LAST, "normalize count overrun")
  `RFC_ASSERT_NEXT(a_done_idle, (state_q == OP_SC2) && stat_i.out_free, state_q == OP_IDLE,
                   "sequencer did not return to idle")
endmodule

// ----- hw/rtl/rfc_datapath.sv -----
`include "rms_feedforward_compressor_top_macros.svh"

module rfc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfc_pkg::cmd_t    cmd_i,
  input  rfc_pkg::cfg_t    cfg_i,
  input  rfc_pkg::sample_t sample_a_i,
  input  rfc_pkg::sample_t sample_b_i,
  input  logic             out_ready_i,
  output rfc_pkg::stat_t   stat_o,
  output logic             out_valid_o,
  output rfc_pkg::sample_t out_a_o,
  output rfc_pkg::sample_t out_b_o
);
  import rfc_pkg::*;

  function automatic logic [23:0] sat_coef(input logic [23:0] c);
    return (c > ONE_Q23) ? ONE_Q23 : c;
  endfunction

  function automatic logic [23:0] mag24(input logic [23:0] s);
    return s[23] ? (~s + 24'd1) : s;
  endfunction

  // Floor of the signed product over 2^16, saturated to 24 bits.
  function automatic logic [23:0] scale_sat(input logic [47:0] p, input logic neg);
    logic [32:0] mag;
    logic [23:0] res;
    if (neg) begin
      mag = 33'((49'(p) + 49'h0_FFFF) >> 16);
      res = (mag > 33'h80_0000) ? 24'h80_0000 : (~mag[23:0] + 24'd1);
    end else begin
      mag = 33'(p >> 16);
      res = (mag > 33'h7F_FFFF) ? 24'h7F_FFFF : mag[23:0];
    end
    return res;
  endfunction

  sample_t     a_q, b_q;
  logic [47:0] ms_q, env_q, sq_q;
  logic [49:0] acc_q;
  logic [23:0] cte_q;
  logic [59:0] hi_q;
  logic        bypass_q;
  logic [63:0] norm_q;
  logic [5:0]  sh_q;
  logic [15:0] frac_q, pg_q;
  logic [21:0] le_q, lt_q;
  logic [22:0] l_q;
  logic [6:0]  k_q;
  logic        fz_q;
  logic [30:0] gain_q;
  logic [23:0] factor_q, sa_q;
  sample_t     out_a_q, out_b_q;
  logic        ovalid_q;
  logic [67:0] prod_q;

  logic        two;
  logic [24:0] mono, mono_mag;
  logic [23:0] rc, rc_inv, cte_inv;
  logic [49:0] y1;
  logic [23:0] cte_next;
  logic [31:0] zz;
  logic [30:0] z_step;
  logic [30:0] v_pow;
  logic [31:0] root_sel;
  logic [21:0] log_val;
  logic [5:0]  amt;
  logic [63:0] top_mask;
  logic [63:0] sum64;
  logic        below;
  logic [22:0] lsum;
  logic [22:0] m_val;
  logic [30:0] g_val;
  logic [15:0] negp;
  logic [23:0] sb_val;
  logic        load, out_free;
  logic [31:0] mul_a;
  logic [35:0] mul_b;
  logic [67:0] prod_d;

  assign two      = (MAX_CHANNELS >= 2) && cfg_i.channel_count[1];
  assign mono     = two ? (25'(a_q) + 25'(b_q)) : {a_q, 1'b0};
  assign mono_mag = mono[24] ? (~mono + 25'd1) : mono;
  assign rc       = sat_coef(cfg_i.rms_coef);
  assign rc_inv   = ONE_Q23 - rc;
  assign cte_inv  = ONE_Q23 - cte_q;
  assign y1       = acc_q + 50'(prod_q[47:23]);
  assign cte_next = sat_coef((y1[47:0] > env_q) ? cfg_i.attack_coef : cfg_i.release_coef);
  assign zz       = prod_q[61:30];
  assign z_step   = zz[31] ? zz[31:1] : zz[30:0];
  assign v_pow    = (cmd_i.cnt == '0) ? ONE_Q30 : prod_q[60:30];
  assign root_sel = pg_q[4'd15 - cmd_i.cnt] ? ROOT_TABLE[cmd_i.cnt] : 32'(ONE_Q30);
  assign log_val  = {6'd63 - sh_q, frac_q};
  assign amt      = 6'd32 >> cmd_i.cnt;
  assign top_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> amt);
  assign sum64    = {hi_q[38:0], 24'b0} + {4'b0, prod_q[59:0]};
  assign below    = (hi_q[59:39] == '0) && !sum64[63];
  assign lsum     = 23'(le_q) + 23'(lt_q);
  assign m_val    = prod_q[38:16];
  assign g_val    = fz_q ? ONE_Q30 : {1'b0, prod_q[60:31]};
  assign negp     = ~cfg_i.gain_exponent + 16'd1;
  assign sb_val   = scale_sat(prod_q[47:0], b_q[23]);
  assign out_free = !ovalid_q || out_ready_i;
  assign load     = (cmd_i.op == OP_SC2) && out_free;

  // Operand select for the shared multiplier; the product is always registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ:   begin mul_a = 32'(mono_mag);       mul_b = 36'(mono_mag);   end
      OP_MS0:  begin mul_a = 32'(prod_q[48:25]);  mul_b = 36'(rc);         end
      OP_MS1:  begin mul_a = 32'(sq_q[23:0]);     mul_b = 36'(rc);         end
      OP_MS2:  begin mul_a = 32'(ms_q[47:24]);    mul_b = 36'(rc_inv);     end
      OP_MS3:  begin mul_a = 32'(ms_q[23:0]);     mul_b = 36'(rc_inv);     end
      OP_EN0:  begin mul_a = 32'(ms_q[47:24]);    mul_b = 36'(cte_inv);    end
      OP_EN1:  begin mul_a = 32'(ms_q[23:0]);     mul_b = 36'(cte_inv);    end
      OP_EN2:  begin mul_a = 32'(env_q[47:24]);   mul_b = 36'(cte_q);      end
      OP_EN3:  begin mul_a = 32'(env_q[23:0]);    mul_b = 36'(cte_q);      end
      OP_TH0:  begin mul_a = 32'(env_q[47:24]);   mul_b = cfg_i.threshold_inverse; end
      OP_TH1:  begin mul_a = 32'(env_q[23:0]);    mul_b = cfg_i.threshold_inverse; end
      OP_LG0:  begin mul_a = 32'(norm_q[63:33]);  mul_b = 36'(norm_q[63:33]); end
      OP_LGS:  begin mul_a = 32'(z_step);         mul_b = 36'(z_step);     end
      OP_MULM: begin mul_a = 32'(l_q);            mul_b = 36'(negp);       end
      OP_POW:  begin mul_a = 32'(v_pow);          mul_b = 36'(root_sel);   end
      OP_FAC0: begin mul_a = 32'(gain_q);         mul_b = 36'(cfg_i.wet_makeup_gain); end
      OP_SC0:  begin mul_a = 32'(mag24(a_q));     mul_b = 36'(factor_q);   end
      OP_SC1:  begin mul_a = 32'(mag24(b_q));     mul_b = 36'(factor_q);   end
      OP_SC2:  begin mul_a = 32'(mag24(b_q));     mul_b = 36'(factor_q);   end
      default: begin mul_a = '0;                  mul_b = '0;              end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.take) begin
      a_q <= sample_a_i;
      b_q <= sample_b_i;
    end
    case (cmd_i.op)
      OP_MS0:  sq_q  <= prod_q[48:1];
      OP_MS1:  acc_q <= 50'({prod_q[47:0], 1'b0});
      OP_MS2:  acc_q <= acc_q + 50'(prod_q[47:23]);
      OP_MS3:  acc_q <= acc_q + 50'({prod_q[47:0], 1'b0});
      OP_MS4:  cte_q <= cte_next;
      OP_EN1:  acc_q <= 50'({prod_q[47:0], 1'b0});
      OP_EN2:  acc_q <= acc_q + 50'(prod_q[47:23]);
      OP_EN3:  acc_q <= acc_q + 50'({prod_q[47:0], 1'b0});
      OP_TH1:  hi_q  <= prod_q[59:0];
      OP_TH2:  bypass_q <= (env_q == '0) || (cfg_i.threshold_inverse == '0) ||
                           !cfg_i.gain_exponent[15] || below;
      OP_NINIT: begin
        norm_q <= cmd_i.sel_ti ? {28'b0, cfg_i.threshold_inverse} : {16'b0, env_q};
        sh_q   <= '0;
      end
      OP_NRM: begin
        if ((norm_q & top_mask) == '0) begin
          norm_q <= norm_q << amt;
          sh_q   <= sh_q + amt;
        end
      end
      OP_LG0:  frac_q <= '0;
      OP_LGS:  frac_q <= {frac_q[14:0], zz[31]};
      OP_LGE: begin
        if (cmd_i.sel_ti) lt_q <= log_val;
        else le_q <= log_val;
      end
      OP_LSUM: l_q <= (lsum > LOG_OFFSET) ? (lsum - LOG_OFFSET) : '0;
      OP_MEND: begin
        k_q  <= m_val[22:16];
        fz_q <= (m_val[15:0] == '0);
        pg_q <= ~m_val[15:0] + 16'd1;
      end
      OP_PEND: gain_q <= (k_q >= 7'd63) ? '0 : (g_val >> k_q);
      OP_BYP:  gain_q <= ONE_Q30;
      OP_FAC1: factor_q <= 24'(25'(cfg_i.dry_gain) + 25'(prod_q[53:30]));
      OP_SC1:  sa_q <= scale_sat(prod_q[47:0], a_q[23]);
      default: ;
    endcase
    if (load) begin
      out_a_q <= sa_q;
      out_b_q <= two ? sb_val : '0;
    end
  end

  // Filter state and the output slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= '0;
      env_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_MS4) ms_q <= y1[47:0];
      if (cmd_i.op == OP_EN4) env_q <= y1[47:0];
      if (load) begin
        if (ms_q <= FLUSH_LIMIT) ms_q <= '0;
        if (env_q <= FLUSH_LIMIT) env_q <= '0;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign stat_o.bypass   = bypass_q;
  assign stat_o.out_free = out_free;
  assign out_valid_o     = ovalid_q;
  assign out_a_o         = out_a_q;
  assign out_b_o         = out_b_q;

  `RFC_ASSERT_NEXT(a_flushed, load,
                   ((ms_q == '0) || (ms_q > FLUSH_LIMIT)) &&
                   ((env_q == '0) || (env_q > FLUSH_LIMIT)), "state not flushed")
  `RFC_ASSERT_IMP(a_log_norm, cmd_i.op == OP_LGS, z_step[30], "log mantissa not normalized")
  `RFC_ASSERT_NEXT(a_out_hold, ovalid_q && !out_ready_i, ovalid_q, "result dropped while stalled")
endmodule

// ----- hw/rtl/rms_feedforward_compressor_top.sv -----
// A result is offered once every step for its frame has run; below threshold, or whenever
// the gain is one, the log and power steps are skipped. Frames are taken one at a time,
// only in idle, which follows once the result can be loaded; the shared multiplier runs
// two 16-step log2 loops and a 16-step exp2 loop one step per cycle.
// Reset: asynchronous, active low; registers take their documented defaults and the
// mean-square and envelope state clear to zero. No clearing pass is needed.
module rms_feedforward_compressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfc_in_if.sink      in_i,
  rfc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [35:0] cfg_wdata_i
);
  import rfc_pkg::*;

  // Configuration registers. Software must write them only while no frame is in flight.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count     <= 2'd2;
      cfg_q.threshold_inverse <= 36'd65536;
      cfg_q.gain_exponent     <= '0;
      cfg_q.attack_coef       <= '0;
      cfg_q.release_coef      <= '0;
      cfg_q.rms_coef          <= ONE_Q23;
      cfg_q.dry_gain          <= '0;
      cfg_q.wet_makeup_gain   <= 23'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CHANNEL_COUNT: cfg_q.channel_count     <= cfg_wdata_i[1:0];
        REG_THRESHOLD_INV: cfg_q.threshold_inverse <= cfg_wdata_i;
        REG_GAIN_EXPONENT: cfg_q.gain_exponent     <= cfg_wdata_i[15:0];
        REG_ATTACK_COEF:   cfg_q.attack_coef       <= cfg_wdata_i[23:0];
        REG_RELEASE_COEF:  cfg_q.release_coef      <= cfg_wdata_i[23:0];
        REG_RMS_COEF:      cfg_q.rms_coef          <= cfg_wdata_i[23:0];
        REG_DRY_GAIN:      cfg_q.dry_gain          <= cfg_wdata_i[16:0];
        REG_WET_MAKEUP:    cfg_q.wet_makeup_gain   <= cfg_wdata_i[22:0];
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;

  // The sequencer walks the frame: detector update, threshold test, two logarithms and
  // the power unless bypassed, the mix factor and the scaling of both channels.
  rfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the single multiplier and all arithmetic state. Its output
  // register lets the next frame be transferred in while a result still waits.
  rfc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .sample_a_i  (in_i.sample_a),
    .sample_b_i  (in_i.sample_b),
    .out_ready_i (out_o.ready),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_a_o     (out_o.out_a),
    .out_b_o     (out_o.out_b)
  );
endmodule

// ----- tb/rfc_tb_if.sv -----
`timescale 1ns / 1ps
// The interfaces of the block live in the RTL; nothing further is needed here.
// This file holds the frame type used by the driver and monitor.
package rfc_tb_pkg;
  typedef struct {
    logic signed [23:0] a;
    logic signed [23:0] b;
  } frame_t;
endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rfc_pkg::*;
  import rfc_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = REG_CHANNEL_COUNT;
  logic [35:0] cfg_wdata_i = '0;

  rfc_in_if in_ch ();
  rfc_out_if out_ch ();

  rms_feedforward_compressor_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the register file and the detector state.
  logic [1:0] chan_cnt;
  logic [35:0] thr_inv;
  logic signed [15:0] gexp;
  logic [23:0] att_c, rel_c, ms_c;
  logic [16:0] dry_g;
  logic [22:0] wet_g;
  logic [63:0] mean_sq, env;
  logic [63:0] root_tab [16];

  frame_t pending_frames[$];
  frame_t expected_out[$];
  int send_idle_pct, recv_idle_pct;
  int error_count = 0;
  int frames_sent = 0, results_seen = 0;
  logic in_taken = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mul_q23(logic [63:0] x, logic [63:0] c);
    return (x >> 24) * c * 2 + (((x & 64'hFFFFFF) * c) >> 23);
  endfunction

  function automatic logic [63:0] clip_coef(logic [23:0] c);
    return (c > ONE_Q23) ? 64'(ONE_Q23) : 64'(c);
  endfunction

  function automatic logic [63:0] log2_q16(logic [63:0] v);
    int e;
    logic [63:0] z, frac;
    e = 63;
    frac = 0;
    while (v[e] == 1'b0) e--;
    z = (e >= 30) ? v >> (e - 30) : v << (30 - e);
    for (int i = 0; i < 16; i++) begin
      z = (z * z) >> 30;
      frac <<= 1;
      if (z >= 64'h8000_0000) begin
        z >>= 1;
        frac |= 1;
      end
    end
    return (64'(e) << 16) + frac;
  endfunction

  // Gain in Q2.30 from the current envelope.
  function automatic logic [63:0] compressor_gain();
    logic [63:0] hi, lo, l, m, g, k, f;
    if (env == 0 || thr_inv == 0 || gexp >= 0) return 64'h4000_0000;
    hi = (env >> 24) * thr_inv;
    lo = (env & 64'hFFFFFF) * thr_inv;
    if (hi < (64'h1 << 39) && (hi << 24) + lo < (64'h1 << 63)) return 64'h4000_0000;
    l = log2_q16(env) + log2_q16(64'(thr_inv));
    l = (l > (64'd63 << 16)) ? l - (64'd63 << 16) : 0;
    m = (l * 64'(-32'(gexp))) >> 16;
    k = m >> 16;
    f = m & 64'hFFFF;
    g = 64'h4000_0000;
    if (f != 0) begin
      for (int j = 0; j < 16; j++)
        if (((64'h10000 - f) >> (15 - j)) & 1) g = (g * root_tab[j]) >> 30;
      g >>= 1;
    end
    return (k >= 63) ? 0 : g >> k;
  endfunction

  function automatic logic signed [23:0] scale_sat(logic signed [23:0] s, logic [63:0] fac);
    longint p, r;
    p = longint'(s) * longint'(fac);
    if (p >= 0) r = p >>> 16;
    else r = -((-p + 65535) >>> 16);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  // Advances the detector by one frame and returns the expected output frame.
  function automatic frame_t compress_frame(frame_t x);
    int cnt;
    longint mono;
    logic [63:0] sq, rc, y1, cte, fac;
    frame_t o;
    cnt = (chan_cnt < 1) ? 1 : (chan_cnt > MAX_CHANNELS) ? MAX_CHANNELS : chan_cnt;
    mono = (cnt >= 2) ? longint'(x.a) + longint'(x.b) : longint'(x.a) * 2;
    sq = 64'(mono * mono) >> 1;
    rc = clip_coef(ms_c);
    y1 = mul_q23(sq, rc) + mul_q23(mean_sq, 64'(ONE_Q23) - rc);
    mean_sq = y1;
    cte = clip_coef(y1 > env ? att_c : rel_c);
    env = mul_q23(y1, 64'(ONE_Q23) - cte) + mul_q23(env, cte);
    fac = 64'(dry_g) + ((compressor_gain() * 64'(wet_g)) >> 30);
    o.a = scale_sat(x.a, fac);
    o.b = (cnt >= 2) ? scale_sat(x.b, fac) : 24'sd0;
    if (mean_sq <= 64'(FLUSH_LIMIT)) mean_sq = 0;
    if (env <= 64'(FLUSH_LIMIT)) env = 0;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s at result %0d: got %0d, expected %0d",
             what, results_seen, $signed(got), $signed(want));
    error_count++;
  endtask

  // Register write at a falling edge; the shadow copy follows immediately.
  task automatic write_reg(logic [2:0] idx, logic [35:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_CHANNEL_COUNT: chan_cnt = val[1:0];
      REG_THRESHOLD_INV: thr_inv = val;
      REG_GAIN_EXPONENT: gexp = val[15:0];
      REG_ATTACK_COEF:   att_c = val[23:0];
      REG_RELEASE_COEF:  rel_c = val[23:0];
      REG_RMS_COEF:      ms_c = val[23:0];
      REG_DRY_GAIN:      dry_g = val[16:0];
      default:           wet_g = val[22:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until the pipeline is drained, then for the block's longest latency.
  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_ch.valid || expected_out.size() != 0)
      @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // Input transfers are seen at the rising edge; the expected result is computed there.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      expected_out.push_back(compress_frame('{a: in_ch.sample_a, b: in_ch.sample_b}));
      frames_sent++;
      in_taken = 1'b1;
    end
  end

  // Driver: a new frame is offered once the previous one has been transferred.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        in_taken = 1'b0;
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.sample_a <= pending_frames[0].a;
          in_ch.sample_b <= pending_frames[0].b;
          void'(pending_frames.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sample the result channel on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        $display("unexpected result with no frame outstanding");
        error_count++;
      end else begin
        if (out_ch.out_a !== expected_out[0].a)
          report_mismatch("out_a", out_ch.out_a, expected_out[0].a);
        if (out_ch.out_b !== expected_out[0].b)
          report_mismatch("out_b", out_ch.out_b, expected_out[0].b);
        void'(expected_out.pop_front());
      end
      results_seen++;
    end
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(255));
      3: return 24'($urandom) >>> $urandom_range(20);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_frames(int n);
    for (int i = 0; i < n; i++)
      pending_frames.push_back('{a: rand_sample(), b: rand_sample()});
  endtask

  // Random settings for one phase; channel count covers the out-of-range codes too.
  task automatic random_settings();
    write_reg(REG_CHANNEL_COUNT, 36'($urandom_range(3)));
    write_reg(REG_THRESHOLD_INV, 36'({$urandom_range(15), $urandom} >> $urandom_range(24)));
    write_reg(REG_GAIN_EXPONENT, 36'($urandom_range(65535)));
    write_reg(REG_ATTACK_COEF,
              $urandom_range(9) == 0 ? 36'hFFFFFF : 36'($urandom_range(8388608)));
    write_reg(REG_RELEASE_COEF,
              $urandom_range(9) == 0 ? 36'hFFFFFF : 36'($urandom_range(8388608)));
    write_reg(REG_RMS_COEF, 36'($urandom_range(8388608)));
    write_reg(REG_DRY_GAIN, 36'($urandom_range(131071)));
    write_reg(REG_WET_MAKEUP, 36'(23'($urandom)));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_a = '0;
    in_ch.sample_b = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 81;
    chan_cnt = 2;
    thr_inv = 65536;
    gexp = 0;
    att_c = 0;
    rel_c = 0;
    ms_c = ONE_Q23;
    dry_g = 0;
    wet_g = 65536;
    mean_sq = 0;
    env = 0;
    root_tab[0] = int_sqrt(64'h1 << 61);
    for (int j = 1; j < 16; j++) root_tab[j] = int_sqrt(root_tab[j - 1] << 30);
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings with full-scale and zero frames.
    pending_frames.push_back('{a: 24'h7FFFFF, b: 24'h7FFFFF});
    pending_frames.push_back('{a: 24'h800000, b: 24'h800000});
    pending_frames.push_back('{a: 24'h0, b: 24'h0});
    pending_frames.push_back('{a: 24'h000001, b: 24'hFFFFFF});
    wait_drained();

    // Directed: heavy compression, low threshold, mono, coefficients above one.
    write_reg(REG_CHANNEL_COUNT, 36'd1);
    write_reg(REG_THRESHOLD_INV, 36'hFFFFFFFFF);
    write_reg(REG_GAIN_EXPONENT, 36'h8000);
    write_reg(REG_ATTACK_COEF, 36'hFFFFFF);
    write_reg(REG_RELEASE_COEF, 36'(ONE_Q23));
    write_reg(REG_RMS_COEF, 36'hFFFFFF);
    write_reg(REG_DRY_GAIN, 36'h1FFFF);
    write_reg(REG_WET_MAKEUP, 36'h7FFFFF);
    pending_frames.push_back('{a: 24'h7FFFFF, b: 24'h123456});
    pending_frames.push_back('{a: 24'h800000, b: 24'h7FFFFF});
    pending_frames.push_back('{a: 24'h000010, b: 24'h0});
    wait_drained();
    // Zero channel count, positive exponent, fast attack.
    write_reg(REG_CHANNEL_COUNT, 36'd0);
    write_reg(REG_GAIN_EXPONENT, 36'h7FFF);
    write_reg(REG_ATTACK_COEF, 36'd0);
    write_reg(REG_RMS_COEF, 36'h400000);
    write_reg(REG_DRY_GAIN, 36'd0);
    pending_frames.push_back('{a: 24'h400000, b: 24'h0});
    pending_frames.push_back('{a: 24'h000100, b: 24'h0});
    wait_drained();
    // Zero threshold inverse, channel count three, then reduce to silence for flush.
    write_reg(REG_CHANNEL_COUNT, 36'd3);
    write_reg(REG_THRESHOLD_INV, 36'd0);
    write_reg(REG_GAIN_EXPONENT, 36'hC000);
    write_reg(REG_RELEASE_COEF, 36'd0);
    write_reg(REG_RMS_COEF, 36'(ONE_Q23));
    pending_frames.push_back('{a: 24'h7FFFFF, b: 24'h800000});
    wait_drained();
    write_reg(REG_THRESHOLD_INV, 36'd65536);
    pending_frames.push_back('{a: 24'h700000, b: 24'h700000});
    pending_frames.push_back('{a: 24'h000001, b: 24'h000000});
    pending_frames.push_back('{a: 24'h0, b: 24'h0});
    wait_drained();

    // Random phases across the three idling regimes.
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 81;
        recv_idle_pct = 33;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      queue_frames(42);
      wait_drained();
    end

    $display("covered %0d frames over directed and 24 random register settings,", frames_sent);
    $display("with sender and receiver stalls in both directions and full rate");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", expected_out.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

// ----- rms_feedforward_compressor_top.f -----
+incdir+hw/rtl
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_if.sv
hw/rtl/rfc_ctrl.sv
hw/rtl/rfc_datapath.sv
hw/rtl/rms_feedforward_compressor_top.sv
tb/rfc_tb_if.sv
tb/testbench.sv
